// ===== rtl/chpe_pkg.sv =====
// shared types, constants and fixed-point helpers of the cubic height profile evaluator
`timescale 1ns / 1ps

package chpe_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int COEFF_FRAC_BITS = 48;

  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_W       = 31;
  localparam int MUL_W       = 32;
  localparam int WORD_W      = 64;
  localparam int PROD_W      = 96;
  localparam int DEN_W       = 3 * LEN_W;
  localparam int QUOT_W      = WORD_W - 1;
  localparam int STEP_W      = 8;
  localparam int Q16_SHIFT   = COEFF_FRAC_BITS - 16;
  localparam int DIV_STEPS_A = WORD_W + 16 + COEFF_FRAC_BITS;
  localparam int DIV_STEPS_B = WORD_W + COEFF_FRAC_BITS;
  localparam int DIV_STEPS_L = WORD_W + 16;

  typedef logic signed [WORD_W-1:0]     s64_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam s64_t S64_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam s64_t S64_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
  localparam s64_t DW_MAX  = s64_t'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam s64_t DW_MIN  = -DW_MAX - 64'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HEIGHT = 3'd0,
    CFG_END_HEIGHT   = 3'd1,
    CFG_START_SLOPE  = 3'd2,
    CFG_END_SLOPE    = 3'd3,
    CFG_CURVE_LENGTH = 3'd4,
    CFG_CURVE_OFFSET = 3'd5,
    CFG_LINEAR_MODE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_E_MUL_A,
    ST_E_ADD_I,
    ST_E_MUL_I,
    ST_E_ADD_T,
    ST_E_MUL_T,
    ST_E_ADD_H,
    ST_E_ADD_S0,
    ST_E_ADD_S1,
    ST_E_ADD_S2,
    ST_E_ADD_S3,
    ST_E_MUL_S,
    ST_E_ADD_V,
    ST_F_START,
    ST_F_LDIV,
    ST_F_MUL_L2,
    ST_F_MUL_L3,
    ST_F_MUL_T1,
    ST_F_MUL_T2,
    ST_F_DIV_A,
    ST_F_DIV_B,
    ST_DONE
  } chpe_state_e;

  function automatic s64_t sext32(input logic [CFG_W-1:0] v);
    return {{(WORD_W - CFG_W){v[CFG_W-1]}}, v};
  endfunction

  function automatic s64_t sext_dw(input data_t v);
    return WORD_W'(v);
  endfunction

  function automatic logic [WORD_W-1:0] mag64(input s64_t v);
    logic [WORD_W-1:0] m;
    m = v;
    if (v[WORD_W-1]) begin
      m = ~m + 64'd1;
    end
    return m;
  endfunction

  function automatic s64_t sadd64(input s64_t a, input s64_t b);
    s64_t r;
    r = a + b;
    if ((a[WORD_W-1] == b[WORD_W-1]) && (r[WORD_W-1] != a[WORD_W-1])) begin
      r = a[WORD_W-1] ? S64_MIN : S64_MAX;
    end
    return r;
  endfunction

  function automatic data_t sat_dw(input s64_t v);
    s64_t r;
    r = v;
    if (v > DW_MAX) begin
      r = DW_MAX;
    end else if (v < DW_MIN) begin
      r = DW_MIN;
    end
    return r[DATA_WIDTH-1:0];
  endfunction

  // product of 16 fraction bits back to the word, truncated toward zero
  function automatic s64_t ms_post(input prod_t p, input logic neg);
    logic [QUOT_W-1:0] m;
    s64_t              r;
    m = (|p[PROD_W-1:QUOT_W+16]) ? {QUOT_W{1'b1}} : p[QUOT_W+15:16];
    r = {1'b0, m};
    if (neg) begin
      r = -r;
    end
    return r;
  endfunction

  function automatic s64_t to_q16(input s64_t v);
    logic [WORD_W-1:0] m;
    s64_t              r;
    m = mag64(v) >> Q16_SHIFT;
    r = m;
    if (v[WORD_W-1]) begin
      r = -r;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cubic_height_profile_eval_core.sv =====
// top level: cubic height profile evaluator with sequencer, shared multiplier and divider
`timescale 1ns / 1ps

// Evaluates y(x) = A*x^3 + B*x^2 + S*x + H0 and dy/dx in Q16.16 along a road profile.
// A transaction with req_type 0 fits A, B and S from the configured heights, slopes and
// length; req_type 1 clamps distance + offset to [0, length] and returns height and slope.
// The block takes one transaction at a time. An evaluate runs four products on the one
// 32x32 multiplier, two partial products each, and eight saturating adds on the one 64-bit
// adder. A cubic fit runs four products and then the bit-serial divider (128 steps for A,
// 112 for B); a linear fit runs one division, and a fit at zero length uses neither unit.
// The result register lets the next transaction be accepted while the previous result
// waits. Coefficients keep what the last fit computed.
module cubic_height_profile_eval_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [chpe_pkg::CFG_W-1:0]   distance_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output chpe_pkg::data_t                     height_o,
  output chpe_pkg::data_t                     slope_o,
  output logic                                degenerate_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [chpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [chpe_pkg::CFG_W-1:0]          cfg_data_i
);

  chpe_pkg::chpe_state_e state_q, state_d;
  logic issued_q, issued_d;
  logic out_valid_q, out_valid_d;
  logic in_accept, out_free, out_load;

  logic [chpe_pkg::CFG_W-1:0] start_height_q, end_height_q, start_slope_q, end_slope_q;
  logic [chpe_pkg::CFG_W-1:0] curve_offset_q;
  logic [chpe_pkg::LEN_W-1:0] curve_length_q;
  logic                       linear_mode_q;
  chpe_pkg::s64_t             cubic_coeff_q, square_coeff_q;
  chpe_pkg::data_t            eff_slope_q;

  logic [chpe_pkg::LEN_W-1:0]   x_q;
  logic                         req_q;
  chpe_pkg::s64_t               ms_q, p1_q, work_q;
  chpe_pkg::data_t              hv_q, sv_q;
  logic [2*chpe_pkg::LEN_W-1:0] l2_q;
  logic [chpe_pkg::DEN_W-1:0]   l3_q;
  logic signed [65:0]           numa_q, numa_d;
  logic signed [66:0]           numb_q, numb_d;
  chpe_pkg::data_t              height_q, slope_q;
  logic                         degen_q;

  logic signed [33:0] xs;
  logic [chpe_pkg::LEN_W-1:0] x_clamp;
  logic signed [32:0] h_w, t1_w;
  logic signed [33:0] t2_w;
  logic signed [65:0] pa66, h17;
  logic signed [66:0] pb67, hx67, h3s;
  logic [65:0] numa_abs;
  logic [66:0] numb_abs;
  chpe_pkg::s64_t qs, lin_v;
  logic len_zero;

  logic                          mul_start, mul_done;
  chpe_pkg::prod_t               mul_prod;
  chpe_pkg::s64_t                op_v;
  logic                          div_start, div_done;
  logic [chpe_pkg::WORD_W-1:0]   div_num;
  logic [chpe_pkg::DEN_W-1:0]    div_den;
  logic [chpe_pkg::STEP_W-1:0]   div_steps;
  logic [chpe_pkg::QUOT_W-1:0]   div_quot;
  chpe_pkg::s64_t                add_a, add_b, add_sum;
  logic                          is_mul, is_div;

  assign in_stall_o  = (state_q != chpe_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == chpe_pkg::ST_DONE) && out_free;
  assign len_zero    = (curve_length_q == '0);

  // clamp of the query distance
  assign xs = {{2{distance_i[31]}}, distance_i} + {{2{curve_offset_q[31]}}, curve_offset_q};
  always_comb begin
    if (xs[33]) begin
      x_clamp = '0;
    end else if (xs[32:0] > {2'b0, curve_length_q}) begin
      x_clamp = curve_length_q;
    end else begin
      x_clamp = xs[chpe_pkg::LEN_W-1:0];
    end
  end

  // fit terms
  assign h_w  = {end_height_q[31], end_height_q} - {start_height_q[31], start_height_q};
  assign t1_w = {start_slope_q[31], start_slope_q} + {end_slope_q[31], end_slope_q};
  assign t2_w = {start_slope_q[31], start_slope_q, 1'b0}
              + {{2{end_slope_q[31]}}, end_slope_q};
  assign pa66 = {2'b0, mul_prod[chpe_pkg::WORD_W-1:0]};
  assign h17  = {{16{h_w[32]}}, h_w, 17'b0};
  assign pb67 = {3'b0, mul_prod[chpe_pkg::WORD_W-1:0]};
  assign hx67 = {{34{h_w[32]}}, h_w};
  assign h3s  = (hx67 <<< 16) + (hx67 <<< 17);
  assign numa_d = (t1_w[32] ? -pa66 : pa66) - h17;
  assign numb_d = h3s - (t2_w[33] ? -pb67 : pb67);
  assign numa_abs = numa_q[65] ? (~numa_q + 66'd1) : numa_q;
  assign numb_abs = numb_q[66] ? (~numb_q + 67'd1) : numb_q;
  assign qs    = {1'b0, div_quot};
  assign lin_v = h_w[32] ? -qs : qs;

  assign add_sum = chpe_pkg::sadd64(add_a, add_b);

  chpe_mul_unit u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (x_q),
    .b_i     (chpe_pkg::mag64(op_v)),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  chpe_div_unit u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chpe_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = req_type_i ? chpe_pkg::ST_E_MUL_A : chpe_pkg::ST_F_START;
        end
      end
      chpe_pkg::ST_E_MUL_A:  if (mul_done) state_d = chpe_pkg::ST_E_ADD_I;
      chpe_pkg::ST_E_ADD_I:  state_d = chpe_pkg::ST_E_MUL_I;
      chpe_pkg::ST_E_MUL_I:  if (mul_done) state_d = chpe_pkg::ST_E_ADD_T;
      chpe_pkg::ST_E_ADD_T:  state_d = chpe_pkg::ST_E_MUL_T;
      chpe_pkg::ST_E_MUL_T:  if (mul_done) state_d = chpe_pkg::ST_E_ADD_H;
      chpe_pkg::ST_E_ADD_H:  state_d = chpe_pkg::ST_E_ADD_S0;
      chpe_pkg::ST_E_ADD_S0: state_d = chpe_pkg::ST_E_ADD_S1;
      chpe_pkg::ST_E_ADD_S1: state_d = chpe_pkg::ST_E_ADD_S2;
      chpe_pkg::ST_E_ADD_S2: state_d = chpe_pkg::ST_E_ADD_S3;
      chpe_pkg::ST_E_ADD_S3: state_d = chpe_pkg::ST_E_MUL_S;
      chpe_pkg::ST_E_MUL_S:  if (mul_done) state_d = chpe_pkg::ST_E_ADD_V;
      chpe_pkg::ST_E_ADD_V:  state_d = chpe_pkg::ST_DONE;
      chpe_pkg::ST_F_START: begin
        priority if (len_zero) begin
          state_d = chpe_pkg::ST_DONE;
        end else if (linear_mode_q) begin
          state_d = chpe_pkg::ST_F_LDIV;
        end else begin
          state_d = chpe_pkg::ST_F_MUL_L2;
        end
      end
      chpe_pkg::ST_F_LDIV:   if (div_done) state_d = chpe_pkg::ST_DONE;
      chpe_pkg::ST_F_MUL_L2: if (mul_done) state_d = chpe_pkg::ST_F_MUL_L3;
      chpe_pkg::ST_F_MUL_L3: if (mul_done) state_d = chpe_pkg::ST_F_MUL_T1;
      chpe_pkg::ST_F_MUL_T1: if (mul_done) state_d = chpe_pkg::ST_F_MUL_T2;
      chpe_pkg::ST_F_MUL_T2: if (mul_done) state_d = chpe_pkg::ST_F_DIV_A;
      chpe_pkg::ST_F_DIV_A:  if (div_done) state_d = chpe_pkg::ST_F_DIV_B;
      chpe_pkg::ST_F_DIV_B:  if (div_done) state_d = chpe_pkg::ST_DONE;
      chpe_pkg::ST_DONE:     if (out_free) state_d = chpe_pkg::ST_IDLE;
      default:               state_d = chpe_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    is_mul    = 1'b0;
    is_div    = 1'b0;
    op_v      = '0;
    add_a     = '0;
    add_b     = '0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    unique case (state_q)
      chpe_pkg::ST_E_MUL_A: begin
        is_mul = 1'b1;
        op_v   = cubic_coeff_q;
      end
      chpe_pkg::ST_E_MUL_I, chpe_pkg::ST_E_MUL_T, chpe_pkg::ST_E_MUL_S: begin
        is_mul = 1'b1;
        op_v   = work_q;
      end
      chpe_pkg::ST_E_ADD_I: begin
        add_a = ms_q;
        add_b = square_coeff_q;
      end
      chpe_pkg::ST_E_ADD_T, chpe_pkg::ST_E_ADD_V: begin
        add_a = chpe_pkg::to_q16(ms_q);
        add_b = chpe_pkg::sext_dw(eff_slope_q);
      end
      chpe_pkg::ST_E_ADD_H: begin
        add_a = ms_q;
        add_b = chpe_pkg::sext32(start_height_q);
      end
      chpe_pkg::ST_E_ADD_S0: begin
        add_a = p1_q;
        add_b = p1_q;
      end
      chpe_pkg::ST_E_ADD_S1: begin
        add_a = work_q;
        add_b = p1_q;
      end
      chpe_pkg::ST_E_ADD_S2: begin
        add_a = square_coeff_q;
        add_b = square_coeff_q;
      end
      chpe_pkg::ST_E_ADD_S3: begin
        add_a = work_q;
        add_b = ms_q;
      end
      chpe_pkg::ST_F_MUL_L2: begin
        is_mul = 1'b1;
        op_v   = {{(chpe_pkg::WORD_W - chpe_pkg::LEN_W){1'b0}}, curve_length_q};
      end
      chpe_pkg::ST_F_MUL_L3: begin
        is_mul = 1'b1;
        op_v   = {{(chpe_pkg::WORD_W - 2 * chpe_pkg::LEN_W){1'b0}}, l2_q};
      end
      chpe_pkg::ST_F_MUL_T1: begin
        is_mul = 1'b1;
        op_v   = {{31{t1_w[32]}}, t1_w};
      end
      chpe_pkg::ST_F_MUL_T2: begin
        is_mul = 1'b1;
        op_v   = {{30{t2_w[33]}}, t2_w};
      end
      chpe_pkg::ST_F_LDIV: begin
        is_div    = 1'b1;
        div_num   = {31'b0, (h_w[32] ? -h_w : h_w)};
        div_den   = {{(chpe_pkg::DEN_W - chpe_pkg::LEN_W){1'b0}}, curve_length_q};
        div_steps = chpe_pkg::STEP_W'(chpe_pkg::DIV_STEPS_L);
      end
      chpe_pkg::ST_F_DIV_A: begin
        is_div    = 1'b1;
        div_num   = numa_abs[chpe_pkg::WORD_W-1:0];
        div_den   = l3_q;
        div_steps = chpe_pkg::STEP_W'(chpe_pkg::DIV_STEPS_A);
      end
      chpe_pkg::ST_F_DIV_B: begin
        is_div    = 1'b1;
        div_num   = numb_abs[chpe_pkg::WORD_W-1:0];
        div_den   = {{(chpe_pkg::DEN_W - 2 * chpe_pkg::LEN_W){1'b0}}, l2_q};
        div_steps = chpe_pkg::STEP_W'(chpe_pkg::DIV_STEPS_B);
      end
      default: begin
      end
    endcase
  end

  assign mul_start = is_mul && !issued_q;
  assign div_start = is_div && !issued_q;

  always_comb begin
    issued_d = issued_q;
    if (mul_done || div_done) begin
      issued_d = 1'b0;
    end else if (mul_start || div_start) begin
      issued_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control, configuration and coefficient state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= chpe_pkg::ST_IDLE;
      issued_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      start_height_q <= '0;
      end_height_q   <= '0;
      start_slope_q  <= '0;
      end_slope_q    <= '0;
      curve_length_q <= '0;
      curve_offset_q <= '0;
      linear_mode_q  <= 1'b0;
      cubic_coeff_q  <= '0;
      square_coeff_q <= '0;
      eff_slope_q    <= '0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (chpe_pkg::cfg_idx_e'(cfg_index_i))
          chpe_pkg::CFG_START_HEIGHT: start_height_q <= cfg_data_i;
          chpe_pkg::CFG_END_HEIGHT:   end_height_q   <= cfg_data_i;
          chpe_pkg::CFG_START_SLOPE:  start_slope_q  <= cfg_data_i;
          chpe_pkg::CFG_END_SLOPE:    end_slope_q    <= cfg_data_i;
          chpe_pkg::CFG_CURVE_LENGTH: curve_length_q <= cfg_data_i[chpe_pkg::LEN_W-1:0];
          chpe_pkg::CFG_CURVE_OFFSET: curve_offset_q <= cfg_data_i;
          chpe_pkg::CFG_LINEAR_MODE:  linear_mode_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (state_q == chpe_pkg::ST_F_START) begin
        cubic_coeff_q  <= '0;
        square_coeff_q <= '0;
        eff_slope_q    <= (len_zero || linear_mode_q) ? '0
                          : chpe_pkg::sat_dw(chpe_pkg::sext32(start_slope_q));
      end
      if (div_done) begin
        if (state_q == chpe_pkg::ST_F_LDIV) begin
          eff_slope_q <= chpe_pkg::sat_dw(lin_v);
        end
        if (state_q == chpe_pkg::ST_F_DIV_A) begin
          cubic_coeff_q <= numa_q[65] ? -qs : qs;
        end
        if (state_q == chpe_pkg::ST_F_DIV_B) begin
          square_coeff_q <= numb_q[66] ? -qs : qs;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= req_type_i;
      x_q   <= req_type_i ? x_clamp : curve_length_q;
    end
    if (mul_done) begin
      unique case (state_q)
        chpe_pkg::ST_F_MUL_L2: l2_q   <= mul_prod[2*chpe_pkg::LEN_W-1:0];
        chpe_pkg::ST_F_MUL_L3: l3_q   <= mul_prod[chpe_pkg::DEN_W-1:0];
        chpe_pkg::ST_F_MUL_T1: numa_q <= numa_d;
        chpe_pkg::ST_F_MUL_T2: numb_q <= numb_d;
        default:               ms_q   <= chpe_pkg::ms_post(mul_prod, op_v[chpe_pkg::WORD_W-1]);
      endcase
    end
    unique case (state_q)
      chpe_pkg::ST_E_ADD_I: begin
        p1_q   <= ms_q;
        work_q <= add_sum;
      end
      chpe_pkg::ST_E_ADD_T, chpe_pkg::ST_E_ADD_S0, chpe_pkg::ST_E_ADD_S1,
      chpe_pkg::ST_E_ADD_S3: work_q <= add_sum;
      chpe_pkg::ST_E_ADD_S2: ms_q <= add_sum;
      chpe_pkg::ST_E_ADD_H:  hv_q <= chpe_pkg::sat_dw(add_sum);
      chpe_pkg::ST_E_ADD_V:  sv_q <= chpe_pkg::sat_dw(add_sum);
      default: begin
      end
    endcase
    if (out_load) begin
      height_q <= req_q ? hv_q : '0;
      slope_q  <= req_q ? sv_q : '0;
      degen_q  <= len_zero;
    end
  end

  assign height_o     = height_q;
  assign slope_o      = slope_q;
  assign degenerate_o = degen_q;

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != chpe_pkg::ST_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == chpe_pkg::ST_DONE))
    else $error("result shown outside the done step");
`endif

endmodule

// ===== rtl/chpe_mul_unit.sv =====
// shared 31 by 64 bit multiplier built from one 32x32 multiplier over two partial products
`timescale 1ns / 1ps

module chpe_mul_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [chpe_pkg::LEN_W-1:0]          a_i,
  input  logic [chpe_pkg::WORD_W-1:0]         b_i,
  output logic                                done_o,
  output chpe_pkg::prod_t                     prod_o
);

  logic                               ph1_q, ph2_q, done_q;
  logic [chpe_pkg::MUL_W-1:0]         a_q, bhi_q;
  logic [chpe_pkg::MUL_W-1:0]         mul_a, mul_b;
  logic [2*chpe_pkg::MUL_W-1:0]       mul_q;
  chpe_pkg::prod_t                    acc_q;

  assign mul_a = start_i ? {1'b0, a_i} : a_q;
  assign mul_b = start_i ? b_i[chpe_pkg::MUL_W-1:0] : bhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q  <= 1'b0;
      ph2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph1_q  <= start_i;
      ph2_q  <= ph1_q;
      done_q <= ph2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {1'b0, a_i};
      bhi_q <= b_i[chpe_pkg::WORD_W-1:chpe_pkg::MUL_W];
    end
    if (start_i || ph1_q) begin
      mul_q <= mul_a * mul_b;
    end
    if (ph1_q) begin
      acc_q <= {{(chpe_pkg::PROD_W - 2 * chpe_pkg::MUL_W){1'b0}}, mul_q};
    end else if (ph2_q) begin
      acc_q <= acc_q + {mul_q, {chpe_pkg::MUL_W{1'b0}}};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/chpe_div_unit.sv =====
// restoring divider, one quotient bit a cycle, quotient saturated to 63 bits
`timescale 1ns / 1ps

module chpe_div_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [chpe_pkg::WORD_W-1:0]     num_i,
  input  logic [chpe_pkg::DEN_W-1:0]      den_i,
  input  logic [chpe_pkg::STEP_W-1:0]     steps_i,
  output logic                            done_o,
  output logic [chpe_pkg::QUOT_W-1:0]     quot_o
);

  logic                           busy_q, done_q, sat_q;
  logic [chpe_pkg::STEP_W-1:0]    cnt_q;
  logic [chpe_pkg::WORD_W-1:0]    num_q, quo_q;
  logic [chpe_pkg::DEN_W-1:0]     den_q, rem_q;
  logic [chpe_pkg::DEN_W:0]       rem_sh, rem_sub;
  logic                           fits;

  assign rem_sh  = {rem_q, num_q[chpe_pkg::WORD_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[chpe_pkg::WORD_W-2:0], 1'b0};
      rem_q <= fits ? rem_sub[chpe_pkg::DEN_W-1:0] : rem_sh[chpe_pkg::DEN_W-1:0];
      quo_q <= {quo_q[chpe_pkg::WORD_W-2:0], fits};
      sat_q <= sat_q | quo_q[chpe_pkg::WORD_W-1] | quo_q[chpe_pkg::WORD_W-2];
    end
  end

  assign done_o = done_q;
  assign quot_o = (sat_q || quo_q[chpe_pkg::WORD_W-1]) ? {chpe_pkg::QUOT_W{1'b1}}
                                                      : quo_q[chpe_pkg::QUOT_W-1:0];

endmodule

// ===== verif/tb_cubic_height_profile_eval_core.sv =====
// self-checking testbench of the cubic height profile evaluator core
`timescale 1ns / 1ps

module tb_cubic_height_profile_eval_core;
  import chpe_pkg::*;

  typedef logic signed [63:0] word_t;

  typedef struct packed {
    data_t height;
    data_t slope;
    logic  degenerate;
  } profile_res_t;

  typedef struct packed {
    logic        wr;
    cfg_idx_e    idx;
    logic        rt;
    logic [31:0] val;
    logic        typed;
    data_t       eh;
    data_t       es;
    logic        ed;
  } plan_row_t;

  localparam logic REQ_FIT   = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;
  localparam logic ROW_WRITE = 1'b1;
  localparam logic ROW_REQ   = 1'b0;
  localparam logic TYPED     = 1'b1;
  localparam logic MODEL     = 1'b0;

  localparam int          N_ITEMS         = 1900;
  localparam int          CALM_AFTER      = 1700;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          N_PLAN          = 25;
  localparam int          CFB             = COEFF_FRAC_BITS;
  localparam logic [63:0] WORD_MAX        = 64'h7fff_ffff_ffff_ffff;
  localparam word_t       DATA_HI         = (word_t'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam word_t       DATA_LO         = -DATA_HI - 1;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               req_type_i;
  logic signed [31:0] distance_i;
  logic               out_valid_o;
  logic               out_stall_i;
  data_t              height_o;
  data_t              slope_o;
  logic               degenerate_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  cubic_height_profile_eval_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .distance_i   (distance_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .height_o     (height_o),
    .slope_o      (slope_o),
    .degenerate_o (degenerate_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow registers and fitted coefficients
  logic signed [31:0] reg_start_h = '0;
  logic signed [31:0] reg_end_h   = '0;
  logic signed [31:0] reg_start_s = '0;
  logic signed [31:0] reg_end_s   = '0;
  logic [30:0]        reg_len     = '0;
  logic signed [31:0] reg_off     = '0;
  logic               reg_linear  = 1'b0;
  word_t              coef_cubic  = '0;
  word_t              coef_square = '0;
  word_t              slope_eff   = '0;

  profile_res_t pending[$];
  profile_res_t typed_res;
  logic         req_typed;
  int           mismatches;
  int           results_seen;
  int           items_sent;
  int unsigned  hold_off_asks;
  logic         calm;
  logic         tx_jitter;
  logic         rx_jitter;

  plan_row_t directed_plan [N_PLAN] = '{
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h0000_0000, TYPED, 32'h0, 32'h0, 1'b1},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h7fff_ffff, TYPED, 32'h0, 32'h0, 1'b1},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h8000_0000, TYPED, 32'h0, 32'h0, 1'b1},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_FIT,  32'h0000_0000, TYPED, 32'h0, 32'h0, 1'b1},
    '{ROW_WRITE, CFG_START_HEIGHT, REQ_EVAL, 32'h8000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h1234_5678, TYPED, 32'h8000_0000, 32'h0, 1'b1},
    '{ROW_WRITE, CFG_END_HEIGHT,   REQ_EVAL, 32'h7fff_ffff, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_CURVE_LENGTH, REQ_EVAL, 32'h7fff_ffff, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_LINEAR_MODE,  REQ_EVAL, 32'h0000_0001, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_FIT,  32'hffff_ffff, TYPED, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h8000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h7fff_ffff, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_CURVE_OFFSET, REQ_EVAL, 32'h7fff_ffff, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h4000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_LINEAR_MODE,  REQ_EVAL, 32'h0000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_START_SLOPE,  REQ_EVAL, 32'h7fff_ffff, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_END_SLOPE,    REQ_EVAL, 32'h8000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_FIT,  32'h0000_0000, TYPED, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h8000_0000, TYPED,
      32'h8000_0000, 32'h7fff_ffff, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h7fff_ffff, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_CURVE_LENGTH, REQ_EVAL, 32'h0000_0001, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_FIT,  32'h0000_0000, TYPED, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h0000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_WRITE, CFG_CURVE_LENGTH, REQ_EVAL, 32'h0000_0000, MODEL, 32'h0, 32'h0, 1'b0},
    '{ROW_REQ,   CFG_START_HEIGHT, REQ_EVAL, 32'h0000_0000, TYPED,
      32'h8000_0000, 32'h7fff_ffff, 1'b1}
  };

  function automatic logic [63:0] magnitude(input word_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic word_t signed_mag(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    c = (m > WORD_MAX) ? WORD_MAX : m;
    return neg ? -word_t'(c) : word_t'(c);
  endfunction

  function automatic word_t add_sat(input word_t a, input word_t b);
    word_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      r = a[63] ? {1'b1, 63'd0} : word_t'(WORD_MAX);
    end
    return r;
  endfunction

  function automatic data_t clamp_data(input word_t v);
    if (v > DATA_HI) begin
      return DATA_HI[DATA_WIDTH-1:0];
    end
    if (v < DATA_LO) begin
      return DATA_LO[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // (x * v) >> 16 toward zero, saturated
  function automatic word_t scale_by(input logic [31:0] x, input word_t v);
    logic [127:0] m;
    m = (128'(x) * 128'(magnitude(v))) >> 16;
    return signed_mag(v[63], (m > 128'(WORD_MAX)) ? WORD_MAX : m[63:0]);
  endfunction

  function automatic word_t frac_to_q16(input word_t v);
    return signed_mag(v[63], magnitude(v) >> (CFB - 16));
  endfunction

  function automatic logic [63:0] div_sat(input logic [63:0] num, input int zeros,
                                          input logic [127:0] den);
    logic [191:0] q;
    q = ({128'd0, num} << zeros) / {64'd0, den};
    return (q > 192'(WORD_MAX)) ? WORD_MAX : q[63:0];
  endfunction

  function automatic logic [64:0] signed_sum(input logic n1, input logic [63:0] m1,
                                             input logic n2, input logic [63:0] m2);
    if (n1 == n2) begin
      return {n1, m1 + m2};
    end
    if (m1 >= m2) begin
      return {n1, m1 - m2};
    end
    return {n2, m2 - m1};
  endfunction

  function automatic void refit();
    word_t        h;
    word_t        s1;
    word_t        s2;
    word_t        t;
    logic [127:0] l;
    logic [64:0]  acc;
    coef_cubic  = '0;
    coef_square = '0;
    slope_eff   = '0;
    if (reg_len == 0) begin
      return;
    end
    l  = 128'(reg_len);
    h  = word_t'(reg_end_h) - word_t'(reg_start_h);
    s1 = word_t'(reg_start_s);
    s2 = word_t'(reg_end_s);
    if (reg_linear) begin
      slope_eff = word_t'(clamp_data(signed_mag(h[63], div_sat(magnitude(h), 16, l))));
      return;
    end
    slope_eff = s1;
    t = s1 + s2;
    acc = signed_sum(t[63], 64'(l) * magnitude(t), !h[63], magnitude(h) << 17);
    coef_cubic = signed_mag(acc[64], div_sat(acc[63:0], 16 + CFB, l * l * l));
    t = 2 * s1 + s2;
    acc = signed_sum(h[63], 3 * (magnitude(h) << 16), !t[63], 64'(l) * magnitude(t));
    coef_square = signed_mag(acc[64], div_sat(acc[63:0], CFB, l * l));
  endfunction

  function automatic profile_res_t profile_step(input logic rt,
                                                input logic signed [31:0] query_dist);
    profile_res_t r;
    word_t        xs;
    word_t        t;
    logic [31:0]  x;
    r = '0;
    r.degenerate = (reg_len == 0);
    if (rt == REQ_FIT) begin
      refit();
      return r;
    end
    xs = word_t'(query_dist) + word_t'(reg_off);
    if (xs < 0) begin
      xs = 0;
    end
    if (xs > word_t'(reg_len)) begin
      xs = word_t'(reg_len);
    end
    x = xs[31:0];
    t = add_sat(scale_by(x, coef_cubic), coef_square);
    t = add_sat(frac_to_q16(scale_by(x, t)), slope_eff);
    r.height = clamp_data(add_sat(scale_by(x, t), word_t'(reg_start_h)));
    t = scale_by(x, coef_cubic);
    t = add_sat(add_sat(t, t), t);
    t = add_sat(t, add_sat(coef_square, coef_square));
    r.slope = clamp_data(add_sat(frac_to_q16(scale_by(x, t)), slope_eff));
    return r;
  endfunction

  function automatic void write_shadow(input cfg_idx_e idx, input logic [31:0] v);
    case (idx)
      CFG_START_HEIGHT: reg_start_h = v;
      CFG_END_HEIGHT:   reg_end_h   = v;
      CFG_START_SLOPE:  reg_start_s = v;
      CFG_END_SLOPE:    reg_end_s   = v;
      CFG_CURVE_LENGTH: reg_len     = v[30:0];
      CFG_CURVE_OFFSET: reg_off     = v;
      CFG_LINEAR_MODE:  reg_linear  = v[0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_word(input int span);
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3, 4:    return $urandom();
      default: return 32'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic [31:0] pick_setting(input cfg_idx_e idx);
    case (idx)
      CFG_START_HEIGHT, CFG_END_HEIGHT: return pick_word(100 << 16);
      CFG_START_SLOPE, CFG_END_SLOPE:   return pick_word(3 << 16);
      CFG_CURVE_OFFSET:                 return pick_word(50 << 16);
      CFG_LINEAR_MODE:                  return 32'($urandom_range(0, 1));
      default: begin
        case ($urandom_range(0, 19))
          0:       return 32'h0;
          1:       return 32'h1;
          2:       return 32'h7fff_ffff;
          3:       return $urandom() & 32'h7fff_ffff;
          4:       return $urandom_range(1, 1 << 16);
          default: return $urandom_range(1 << 16, 300 << 16);
        endcase
      end
    endcase
  endfunction

  // mostly points on the curve, some just past the ends, a few anywhere
  function automatic logic [31:0] pick_distance();
    word_t len_w;
    word_t x;
    len_w = word_t'(reg_len);
    case ($urandom_range(0, 19))
      0, 1:    return $urandom();
      2:       x = 0;
      3:       x = len_w;
      default: x = -(len_w >>> 3) + word_t'($urandom_range(0, 32'(len_w + (len_w >>> 2))));
    endcase
    return 32'(x - word_t'(reg_off));
  endfunction

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    wait_results_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic send_request(input logic rt, input logic [31:0] query_dist,
                              input logic typed, input profile_res_t want);
    if (!calm && tx_jitter && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    cfg_valid_i <= 1'b0;
    req_type_i  <= rt;
    distance_i  <= query_dist;
    req_typed   = typed;
    typed_res   = want;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (items_sent >= CALM_AFTER) begin
      calm = 1'b1;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver side: short stall bursts, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    int unsigned hold_seen;
    hold_left   = 0;
    burst_left  = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_off_asks) begin
        hold_seen = hold_off_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (!calm && rx_jitter && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    profile_res_t want;
    profile_res_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        write_shadow(cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && !in_stall_o) begin
        want = profile_step(req_type_i, distance_i);
        if (req_typed) begin
          want = typed_res;
        end
        pending.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got.height     = height_o;
        got.slope      = slope_o;
        got.degenerate = degenerate_o;
        results_seen++;
        if (pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d with none pending: height %h slope %h degenerate %b",
                     results_seen, got.height, got.slope, got.degenerate);
          end
        end else begin
          want = pending.pop_front();
          if (got.height !== want.height || got.slope !== want.slope ||
              got.degenerate !== want.degenerate) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: height exp %h got %h, slope exp %h got %h, %s%b got %b",
                       results_seen, want.height, got.height, want.slope, got.slope,
                       "degenerate exp ", want.degenerate, got.degenerate);
            end
          end
        end
      end
    end
  end

  initial begin
    int phase;
    int n_req;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_FIT;
    distance_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_START_HEIGHT;
    cfg_data_i    = '0;
    req_typed     = 1'b0;
    typed_res     = '0;
    mismatches    = 0;
    results_seen  = 0;
    items_sent    = 0;
    hold_off_asks = 0;
    calm          = 1'b0;
    tx_jitter     = 1'b1;
    rx_jitter     = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].wr) begin
        write_reg(directed_plan[i].idx, directed_plan[i].val);
      end else begin
        send_request(directed_plan[i].rt, directed_plan[i].val, directed_plan[i].typed,
                     {directed_plan[i].eh, directed_plan[i].es, directed_plan[i].ed});
      end
    end

    // each phase: new settings while idle, usually a fit, then a run of evaluations
    phase = 0;
    while (items_sent < N_ITEMS) begin
      tx_jitter = ($urandom_range(0, 3) != 0);
      rx_jitter = ($urandom_range(0, 3) != 0);
      for (int r = CFG_START_HEIGHT; r <= CFG_LINEAR_MODE; r++) begin
        if (phase == 0 || $urandom_range(0, 1) == 1) begin
          write_reg(cfg_idx_e'(r), pick_setting(cfg_idx_e'(r)));
        end
      end
      n_req = $urandom_range(10, 40);
      if (phase == 3) begin
        tx_jitter = 1'b0;
        n_req     = 40;
        hold_off_asks++;
      end
      if ($urandom_range(0, 7) != 0) begin
        send_request(REQ_FIT, $urandom(), MODEL, '0);
      end
      repeat (n_req) begin
        if ($urandom_range(0, 24) == 0) begin
          send_request(REQ_FIT, $urandom(), MODEL, '0);
        end else begin
          send_request(REQ_EVAL, pick_distance(), MODEL, '0);
        end
      end
      wait_results_drained();
      phase++;
    end

    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
